// ----- sv/blm_pkg.sv -----
// ----------------------------------------------------------------------------
// blm_pkg: shared types and constants of the battery level monitor
// Ring geometry, level state codes, configuration register map and the
// structs passed between the monitor's modules.
// ----------------------------------------------------------------------------
package blm_pkg;

    // Ring geometry. The depth must be a power of two so that the rounded
    // average is a plain shift of the ring sum.
    localparam int RING_DEPTH    = 16;
    localparam int SAMPLE_BITS   = 10;
    localparam int RING_IDX_BITS = $clog2(RING_DEPTH);
    localparam int SUM_BITS      = SAMPLE_BITS + RING_IDX_BITS;

    // Battery level state codes.
    localparam logic [1:0] LVL_OK   = 2'd0;
    localparam logic [1:0] LVL_LOW  = 2'd1;
    localparam logic [1:0] LVL_CRIT = 2'd2;
    localparam logic [1:0] LVL_USB  = 2'd3;

    // Configuration register map.
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 10;
    localparam logic [CFG_IDX_BITS-1:0] REG_LOW_LEVEL      = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CRITICAL_LEVEL = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_HYSTERESIS     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE       = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_SHUTDOWN       = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_LOW_WARN_EN    = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_CRIT_WARN_EN   = 3'd6;

    typedef struct packed {
        logic [9:0] low_level;
        logic [9:0] critical_level;
        logic [9:0] hysteresis;
        logic [7:0] debounce_count;
        logic [7:0] shutdown_timeout;
        logic       low_warn_enable;
        logic       critical_warn_enable;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        low_level:            10'd850,
        critical_level:       10'd800,
        hysteresis:           10'd10,
        debounce_count:       8'd3,
        shutdown_timeout:     8'd60,
        low_warn_enable:      1'b1,
        critical_warn_enable: 1'b1
    };

    // Per-cell control of the sample chain.
    typedef struct packed {
        logic load;   // take the load value (ring fill)
        logic step;   // take the neighbor's value
    } t_cell_ctl;

    // Control of the whole ring.
    typedef struct packed {
        logic fill;      // load every cell with the new sample
        logic shift_in;  // shift the new sample into the head cell
        logic rotate;    // rotate by one cell and accumulate the tail
    } t_ring_ctl;

    // One result item.
    typedef struct packed {
        logic [1:0]             battery_state;
        logic [SAMPLE_BITS-1:0] average;
        logic                   low_flag;
        logic                   critical_flag;
        logic                   low_warning;
        logic                   critical_warning;
        logic                   power_down;
    } t_result;

endpackage

// ----- sv/battery_level_monitor.sv -----
// ----------------------------------------------------------------------------
// battery_level_monitor: battery level supervisor with shutdown countdown
// Averages a ring of battery samples and tracks an ok / low / critical /
// USB-powered state with debounce, hysteresis and a power-down timer.
// ----------------------------------------------------------------------------
// Usage:
// Each input transfer (i_valid and o_ready high) is one periodic tick carrying
// a converter sample and the USB-power flag. Each tick yields exactly one
// result transfer (o_valid and i_ready high) with the new state, average,
// flags and the one-tick warning and power-down pulses.
// The sample enters the head of a chain of RING_DEPTH cells. The chain then
// rotates once around, one cell per cycle, while the tail value is added into
// an accumulator. A new tick is taken as soon as the previous one has handed
// its result to the output register, even while that result still waits.
// If the receiver stalls, the finished result is held in the update step and
// no further tick is taken until the output register frees up.
// While the stored average is zero (as after reset) the whole chain is loaded
// with the current sample instead. Reset restores the register defaults and
// clears the level state, counters, countdown and stored average; the sample
// chain needs no clearing pass since the first tick fills it.
// Configuration writes take effect at once and belong to idle periods.
// ----------------------------------------------------------------------------
module battery_level_monitor (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [blm_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [blm_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    // tick input
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [blm_pkg::SAMPLE_BITS-1:0]     i_sample,
    input  logic                                i_usb_powered,
    // result output
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [1:0]                          o_battery_state,
    output logic [blm_pkg::SAMPLE_BITS-1:0]     o_average,
    output logic                                o_low_flag,
    output logic                                o_critical_flag,
    output logic                                o_low_warning,
    output logic                                o_critical_warning,
    output logic                                o_power_down
);

    // Sequencer states.
    localparam logic [1:0] SEQ_IDLE   = 2'd0;
    localparam logic [1:0] SEQ_SUM    = 2'd1;
    localparam logic [1:0] SEQ_UPDATE = 2'd2;

    localparam logic [blm_pkg::RING_IDX_BITS-1:0] LAST_CELL =
        blm_pkg::RING_IDX_BITS'(blm_pkg::RING_DEPTH - 1);

    logic [1:0]                         r_seq;
    logic [1:0]                         n_seq;
    logic [blm_pkg::RING_IDX_BITS-1:0]  r_cnt;
    logic                               r_usb;
    blm_pkg::t_cfg                      r_cfg;
    blm_pkg::t_result                   r_out;
    logic                               r_out_valid;

    logic                               w_accept;
    logic                               w_out_free;
    logic                               w_update;
    logic                               w_avg_zero;
    blm_pkg::t_ring_ctl                 w_ring_ctl;
    logic [blm_pkg::SUM_BITS-1:0]       w_sum;
    blm_pkg::t_result                   w_result;

    assign o_ready    = (r_seq == SEQ_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;
    assign w_update   = (r_seq == SEQ_UPDATE) && w_out_free;

    // Configuration registers; data is truncated to each register's width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= blm_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                blm_pkg::REG_LOW_LEVEL:      r_cfg.low_level <= i_cfg_data;
                blm_pkg::REG_CRITICAL_LEVEL: r_cfg.critical_level <= i_cfg_data;
                blm_pkg::REG_HYSTERESIS:     r_cfg.hysteresis <= i_cfg_data;
                blm_pkg::REG_DEBOUNCE:       r_cfg.debounce_count <= i_cfg_data[7:0];
                blm_pkg::REG_SHUTDOWN:       r_cfg.shutdown_timeout <= i_cfg_data[7:0];
                blm_pkg::REG_LOW_WARN_EN:    r_cfg.low_warn_enable <= i_cfg_data[0];
                blm_pkg::REG_CRIT_WARN_EN:   r_cfg.critical_warn_enable <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // The transfer cycle inserts the sample; the sum phase rotates the chain.
    assign w_ring_ctl.fill     = w_accept && w_avg_zero;
    assign w_ring_ctl.shift_in = w_accept && !w_avg_zero;
    assign w_ring_ctl.rotate   = (r_seq == SEQ_SUM);

    always_comb begin
        n_seq = r_seq;
        case (r_seq)
            SEQ_IDLE: begin
                if (w_accept) begin
                    n_seq = SEQ_SUM;
                end
            end
            SEQ_SUM: begin
                if (r_cnt == LAST_CELL) begin
                    n_seq = SEQ_UPDATE;
                end
            end
            SEQ_UPDATE: begin
                if (w_out_free) begin
                    n_seq = SEQ_IDLE;
                end
            end
            default: begin
                n_seq = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= SEQ_IDLE;
            r_cnt <= '0;
        end else begin
            r_seq <= n_seq;
            if (r_seq == SEQ_SUM) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_usb <= i_usb_powered;
        end
    end

    blm_ring u_ring (
        .i_clk    (i_clk),
        .i_ctl    (w_ring_ctl),
        .i_sample (i_sample),
        .o_sum    (w_sum)
    );

    blm_level u_level (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_update   (w_update),
        .i_sum      (w_sum),
        .i_usb      (r_usb),
        .o_avg_zero (w_avg_zero),
        .o_result   (w_result)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_update) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_update) begin
            r_out <= w_result;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_battery_state    = r_out.battery_state;
    assign o_average          = r_out.average;
    assign o_low_flag         = r_out.low_flag;
    assign o_critical_flag    = r_out.critical_flag;
    assign o_low_warning      = r_out.low_warning;
    assign o_critical_warning = r_out.critical_warning;
    assign o_power_down       = r_out.power_down;

endmodule

// ----- sv/blm_cell.sv -----
// ----------------------------------------------------------------------------
// blm_cell: one storage cell of the sample chain
// Holds one sample and takes either the fill value or its neighbor's value.
// ----------------------------------------------------------------------------
module blm_cell (
    input  logic                            i_clk,
    input  blm_pkg::t_cell_ctl              i_ctl,
    input  logic [blm_pkg::SAMPLE_BITS-1:0] i_load_val,
    input  logic [blm_pkg::SAMPLE_BITS-1:0] i_prev,
    output logic [blm_pkg::SAMPLE_BITS-1:0] o_val
);

    logic [blm_pkg::SAMPLE_BITS-1:0] r_val;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_val <= i_load_val;
        end else if (i_ctl.step) begin
            r_val <= i_prev;
        end
    end

    assign o_val = r_val;

endmodule

// ----- sv/blm_ring.sv -----
// ----------------------------------------------------------------------------
// blm_ring: sample chain with tail accumulator
// A row of cells that is filled or shifts new samples in and, while
// summing, rotates once around so every entry passes the tail adder exactly once.
// ----------------------------------------------------------------------------
module blm_ring (
    input  logic                            i_clk,
    input  blm_pkg::t_ring_ctl              i_ctl,
    input  logic [blm_pkg::SAMPLE_BITS-1:0] i_sample,
    output logic [blm_pkg::SUM_BITS-1:0]    o_sum
);

    logic [blm_pkg::SAMPLE_BITS-1:0] w_val [blm_pkg::RING_DEPTH];
    logic [blm_pkg::SAMPLE_BITS-1:0] w_head_in;
    blm_pkg::t_cell_ctl              w_cell_ctl;
    logic [blm_pkg::SUM_BITS-1:0]    r_acc;

    assign w_cell_ctl.load = i_ctl.fill;
    assign w_cell_ctl.step = i_ctl.shift_in | i_ctl.rotate;

    // The head cell closes the loop while rotating.
    assign w_head_in = i_ctl.rotate ? w_val[blm_pkg::RING_DEPTH-1] : i_sample;

    for (genvar g = 0; g < blm_pkg::RING_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            blm_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_cell_ctl),
                .i_load_val (i_sample),
                .i_prev     (w_head_in),
                .o_val      (w_val[g])
            );
        end else begin : g_body
            blm_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_cell_ctl),
                .i_load_val (i_sample),
                .i_prev     (w_val[g-1]),
                .o_val      (w_val[g])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.fill || i_ctl.shift_in) begin
            r_acc <= '0;
        end else if (i_ctl.rotate) begin
            r_acc <= r_acc + blm_pkg::SUM_BITS'(w_val[blm_pkg::RING_DEPTH-1]);
        end
    end

    assign o_sum = r_acc;

endmodule

// ----- sv/blm_level.sv -----
// ----------------------------------------------------------------------------
// blm_level: battery level state machine
// Rounds the ring sum to the average and updates the level state, the
// debounce counters and the shutdown countdown once per tick.
// ----------------------------------------------------------------------------
module blm_level (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  blm_pkg::t_cfg                i_cfg,
    input  logic                         i_update,
    input  logic [blm_pkg::SUM_BITS-1:0] i_sum,
    input  logic                         i_usb,
    output logic                         o_avg_zero,
    output blm_pkg::t_result             o_result
);

    localparam int RSUM_BITS = blm_pkg::SUM_BITS + 1;

    logic [blm_pkg::SAMPLE_BITS-1:0] r_average;
    logic [1:0]                      r_level;
    logic [7:0]                      r_low_hits;
    logic [7:0]                      r_crit_hits;
    logic [7:0]                      r_countdown;

    logic [RSUM_BITS-1:0]            w_rsum;
    logic [blm_pkg::SAMPLE_BITS-1:0] w_avg;
    logic [10:0]                     w_ok_bound;

    logic [1:0] n_level;
    logic [7:0] n_low_hits;
    logic [7:0] n_crit_hits;
    logic [7:0] n_countdown;
    logic       n_low_warn;
    logic       n_crit_warn;
    logic       n_power_down;

    // Half rounds up.
    assign w_rsum = RSUM_BITS'(i_sum) + RSUM_BITS'(blm_pkg::RING_DEPTH / 2);
    assign w_avg  = w_rsum[blm_pkg::RING_IDX_BITS +: blm_pkg::SAMPLE_BITS];
    assign w_ok_bound = {1'b0, i_cfg.low_level} + {1'b0, i_cfg.hysteresis};

    always_comb begin
        n_level      = r_level;
        n_low_hits   = r_low_hits;
        n_crit_hits  = r_crit_hits;
        n_countdown  = r_countdown;
        n_low_warn   = 1'b0;
        n_crit_warn  = 1'b0;
        n_power_down = 1'b0;

        case (r_level)
            blm_pkg::LVL_OK, blm_pkg::LVL_LOW: begin
                if (i_usb) begin
                    n_level = blm_pkg::LVL_USB;
                end else if (w_avg <= i_cfg.critical_level) begin
                    n_crit_hits = r_crit_hits + 8'd1;
                    if (n_crit_hits >= i_cfg.debounce_count) begin
                        n_level     = blm_pkg::LVL_CRIT;
                        n_crit_warn = i_cfg.critical_warn_enable;
                        if (r_countdown == 8'd0) begin
                            n_countdown = i_cfg.shutdown_timeout;
                        end
                    end
                end else if (r_level == blm_pkg::LVL_OK) begin
                    if (w_avg <= i_cfg.low_level) begin
                        n_crit_hits = 8'd0;
                        n_low_hits  = r_low_hits + 8'd1;
                        if (n_low_hits >= i_cfg.debounce_count) begin
                            n_level     = blm_pkg::LVL_LOW;
                            n_low_warn  = i_cfg.low_warn_enable;
                            n_countdown = 8'd0;
                        end
                    end else begin
                        n_low_hits  = 8'd0;
                        n_crit_hits = 8'd0;
                    end
                end else if ({1'b0, w_avg} >= w_ok_bound) begin
                    n_level     = blm_pkg::LVL_OK;
                    n_low_hits  = 8'd0;
                    n_crit_hits = 8'd0;
                    n_countdown = 8'd0;
                end else begin
                    n_crit_hits = 8'd0;
                end
            end
            blm_pkg::LVL_CRIT: begin
                if (i_usb) begin
                    n_level     = blm_pkg::LVL_USB;
                    n_countdown = 8'd0;
                end
            end
            default: begin
                if (!i_usb) begin
                    n_level     = blm_pkg::LVL_OK;
                    n_low_hits  = 8'd0;
                    n_crit_hits = 8'd0;
                end
            end
        endcase

        // The countdown runs after the state update.
        if (n_countdown != 8'd0) begin
            n_countdown  = n_countdown - 8'd1;
            n_power_down = (n_countdown == 8'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_average   <= '0;
            r_level     <= blm_pkg::LVL_OK;
            r_low_hits  <= '0;
            r_crit_hits <= '0;
            r_countdown <= '0;
        end else if (i_update) begin
            r_average   <= w_avg;
            r_level     <= n_level;
            r_low_hits  <= n_low_hits;
            r_crit_hits <= n_crit_hits;
            r_countdown <= n_countdown;
        end
    end

    assign o_avg_zero = (r_average == '0);

    always_comb begin
        o_result.battery_state    = n_level;
        o_result.average          = w_avg;
        o_result.low_flag         = (n_level == blm_pkg::LVL_LOW) ||
                                    (n_level == blm_pkg::LVL_CRIT);
        o_result.critical_flag    = (n_level == blm_pkg::LVL_CRIT);
        o_result.low_warning      = n_low_warn;
        o_result.critical_warning = n_crit_warn;
        o_result.power_down       = n_power_down;
    end

endmodule

// ----- sv/blm_checker.sv -----
// ----------------------------------------------------------------------------
// blm_checker: port-level checks of the battery level monitor
// Watches the top level's ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
module blm_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_ready,
    input logic                            o_valid,
    input logic                            i_ready,
    input logic [1:0]                      o_battery_state,
    input logic [blm_pkg::SAMPLE_BITS-1:0] o_average,
    input logic                            o_low_flag,
    input logic                            o_critical_flag
);

    // No result is pending right after reset.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // A tick is summed in the sum phase, so no second transfer follows at once.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input ready again right after a transfer");

    // The flags agree with the reported state.
    a_flags_match_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_critical_flag == (o_battery_state == blm_pkg::LVL_CRIT)) &&
                    (o_low_flag == ((o_battery_state == blm_pkg::LVL_LOW) ||
                                    (o_battery_state == blm_pkg::LVL_CRIT))))
        else $error("flags disagree with battery state");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid && $stable(o_average) &&
                                  $stable(o_battery_state))
        else $error("stalled result changed");

endmodule

bind battery_level_monitor blm_checker u_blm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_battery_state (o_battery_state),
    .o_average       (o_average),
    .o_low_flag      (o_low_flag),
    .o_critical_flag (o_critical_flag)
);

// ----- verif/battery_level_monitor_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// battery_level_monitor_tb: self-checking bench for the battery level monitor
// Feeds battery ticks through the valid/ready input with bursty timing,
// predicts every report from a behavioral copy of the ring average and level
// state machine, and checks each report transfer under receiver back-pressure
// across several register settings, the extremes among them.
// ----------------------------------------------------------------------------
module battery_level_monitor_tb;

    // Index past the register map; writes to it must be ignored.
    localparam logic [blm_pkg::CFG_IDX_BITS-1:0] REG_UNMAPPED = 3'd7;
    localparam int MAX_SAMPLE = (1 << blm_pkg::SAMPLE_BITS) - 1;

    typedef struct {
        logic [blm_pkg::SAMPLE_BITS-1:0] sample;
        logic                            usb;
    } t_tick;

    // Clock and block inputs, all known from time zero.
    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_cfg_we = 1'b0;
    logic [blm_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx = '0;
    logic [blm_pkg::CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic                              i_valid = 1'b0;
    logic [blm_pkg::SAMPLE_BITS-1:0]   i_sample = '0;
    logic                              i_usb_powered = 1'b0;
    logic                              i_ready = 1'b0;

    logic                              o_ready;
    logic                              o_valid;
    logic [1:0]                        o_battery_state;
    logic [blm_pkg::SAMPLE_BITS-1:0]   o_average;
    logic                              o_low_flag;
    logic                              o_critical_flag;
    logic                              o_low_warning;
    logic                              o_critical_warning;
    logic                              o_power_down;

    battery_level_monitor u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_sample           (i_sample),
        .i_usb_powered      (i_usb_powered),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_battery_state    (o_battery_state),
        .o_average          (o_average),
        .o_low_flag         (o_low_flag),
        .o_critical_flag    (o_critical_flag),
        .o_low_warning      (o_low_warning),
        .o_critical_warning (o_critical_warning),
        .o_power_down       (o_power_down)
    );

    always #4 i_clk = ~i_clk;

    // Ticks waiting to be driven, and the reports predicted for ticks that
    // have already been transferred into the block.
    t_tick            ticks_to_send[$];
    blm_pkg::t_result expected_reports[$];

    // Shadow of the configuration registers as the block should hold them.
    blm_pkg::t_cfg cfg_shadow;

    // Behavioral copy of the block's state.
    logic [blm_pkg::SAMPLE_BITS-1:0]   ring_copy [blm_pkg::RING_DEPTH];
    logic [blm_pkg::RING_IDX_BITS-1:0] ring_wr_pos;
    logic [blm_pkg::SAMPLE_BITS-1:0]   avg_copy;
    logic [1:0]                        level_copy;
    logic [7:0]                        low_hit_cnt;
    logic [7:0]                        crit_hit_cnt;
    logic [7:0]                        shutdown_cnt;

    // Bookkeeping of the run.
    int   ticks_presented = 0;
    int   ticks_accepted = 0;
    int   reports_checked = 0;
    int   mismatch_count = 0;
    int   settings_used = 0;
    int   low_warn_seen = 0;
    int   crit_warn_seen = 0;
    int   power_down_seen = 0;
    logic [3:0] states_seen = '0;

    // Sender burst shaping and receiver stall pattern.
    int    burst_left = 8;
    int    gap_left = 0;
    int    ready_left = 0;
    logic  ready_level = 1'b1;
    t_tick next_tick;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    task automatic clear_level_model();
        cfg_shadow   = blm_pkg::CFG_RESET;
        ring_wr_pos  = '0;
        avg_copy     = '0;
        level_copy   = blm_pkg::LVL_OK;
        low_hit_cnt  = '0;
        crit_hit_cnt = '0;
        shutdown_cnt = '0;
    endtask

    // Entering critical raises the warning when enabled and arms the
    // countdown only if it is not already running.
    task automatic enter_critical_level(inout logic crit_warn);
        level_copy = blm_pkg::LVL_CRIT;
        if (cfg_shadow.critical_warn_enable) begin
            crit_warn = 1'b1;
        end
        if (shutdown_cnt == 0) begin
            shutdown_cnt = cfg_shadow.shutdown_timeout;
        end
    endtask

    // Advances the behavioral state by one tick and returns the report that
    // the block should produce for it.
    task automatic predict_report(input logic [blm_pkg::SAMPLE_BITS-1:0] smp,
                                  input logic usb,
                                  output blm_pkg::t_result rep);
        int   ring_sum;
        int   ok_bound;
        logic low_warn;
        logic crit_warn;
        logic pwr_down;
        low_warn  = 1'b0;
        crit_warn = 1'b0;
        pwr_down  = 1'b0;

        // A zero average means the ring holds nothing useful yet, so the
        // whole ring takes the current sample.
        if (avg_copy == 0) begin
            for (int k = 0; k < blm_pkg::RING_DEPTH; k++) begin
                ring_copy[k] = smp;
            end
            ring_wr_pos = '0;
        end else begin
            ring_copy[ring_wr_pos] = smp;
            ring_wr_pos = ring_wr_pos + 1'b1;
        end

        ring_sum = 0;
        for (int k = 0; k < blm_pkg::RING_DEPTH; k++) begin
            ring_sum += ring_copy[k];
        end
        avg_copy = blm_pkg::SAMPLE_BITS'((ring_sum + blm_pkg::RING_DEPTH / 2) /
                                         blm_pkg::RING_DEPTH);

        // The return bound is formed without wrap, so it may lie beyond
        // the largest possible average.
        ok_bound = int'(cfg_shadow.low_level) + int'(cfg_shadow.hysteresis);

        case (level_copy)
            blm_pkg::LVL_OK: begin
                if (usb) begin
                    level_copy = blm_pkg::LVL_USB;
                end else if (avg_copy <= cfg_shadow.critical_level) begin
                    crit_hit_cnt = crit_hit_cnt + 8'd1;
                    if (crit_hit_cnt >= cfg_shadow.debounce_count) begin
                        enter_critical_level(crit_warn);
                    end
                end else if (avg_copy <= cfg_shadow.low_level) begin
                    crit_hit_cnt = '0;
                    low_hit_cnt  = low_hit_cnt + 8'd1;
                    if (low_hit_cnt >= cfg_shadow.debounce_count) begin
                        level_copy   = blm_pkg::LVL_LOW;
                        low_warn     = cfg_shadow.low_warn_enable;
                        shutdown_cnt = '0;
                    end
                end else begin
                    low_hit_cnt  = '0;
                    crit_hit_cnt = '0;
                end
            end
            blm_pkg::LVL_LOW: begin
                if (usb) begin
                    level_copy = blm_pkg::LVL_USB;
                end else if (avg_copy <= cfg_shadow.critical_level) begin
                    crit_hit_cnt = crit_hit_cnt + 8'd1;
                    if (crit_hit_cnt >= cfg_shadow.debounce_count) begin
                        enter_critical_level(crit_warn);
                    end
                end else if (int'(avg_copy) >= ok_bound) begin
                    level_copy   = blm_pkg::LVL_OK;
                    low_hit_cnt  = '0;
                    crit_hit_cnt = '0;
                    shutdown_cnt = '0;
                end else begin
                    crit_hit_cnt = '0;
                end
            end
            blm_pkg::LVL_CRIT: begin
                if (usb) begin
                    level_copy   = blm_pkg::LVL_USB;
                    shutdown_cnt = '0;
                end
            end
            default: begin
                if (!usb) begin
                    level_copy   = blm_pkg::LVL_OK;
                    low_hit_cnt  = '0;
                    crit_hit_cnt = '0;
                end
            end
        endcase

        // The countdown runs after the state update, so a timeout of one
        // asks for power-down on the very tick that enters critical.
        if (shutdown_cnt != 0) begin
            shutdown_cnt = shutdown_cnt - 8'd1;
            pwr_down = (shutdown_cnt == 0);
        end

        rep.battery_state    = level_copy;
        rep.average          = avg_copy;
        rep.low_flag         = (level_copy == blm_pkg::LVL_LOW) ||
                               (level_copy == blm_pkg::LVL_CRIT);
        rep.critical_flag    = (level_copy == blm_pkg::LVL_CRIT);
        rep.low_warning      = low_warn;
        rep.critical_warning = crit_warn;
        rep.power_down       = pwr_down;
    endtask

    // ------------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------------

    // One register write on the plain write port. The shadow keeps only the
    // bits that the register is wide enough to hold.
    task automatic write_register(input logic [blm_pkg::CFG_IDX_BITS-1:0] idx,
                                  input logic [blm_pkg::CFG_DATA_BITS-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        case (idx)
            blm_pkg::REG_LOW_LEVEL:      cfg_shadow.low_level            = data[9:0];
            blm_pkg::REG_CRITICAL_LEVEL: cfg_shadow.critical_level       = data[9:0];
            blm_pkg::REG_HYSTERESIS:     cfg_shadow.hysteresis           = data[9:0];
            blm_pkg::REG_DEBOUNCE:       cfg_shadow.debounce_count       = data[7:0];
            blm_pkg::REG_SHUTDOWN:       cfg_shadow.shutdown_timeout     = data[7:0];
            blm_pkg::REG_LOW_WARN_EN:    cfg_shadow.low_warn_enable      = data[0];
            blm_pkg::REG_CRIT_WARN_EN:   cfg_shadow.critical_warn_enable = data[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic apply_settings(input int low_lvl, input int crit_lvl, input int hyst,
                                  input int debounce, input int timeout,
                                  input int low_en, input int crit_en);
        write_register(blm_pkg::REG_LOW_LEVEL,      blm_pkg::CFG_DATA_BITS'(low_lvl));
        write_register(blm_pkg::REG_CRITICAL_LEVEL, blm_pkg::CFG_DATA_BITS'(crit_lvl));
        write_register(blm_pkg::REG_HYSTERESIS,     blm_pkg::CFG_DATA_BITS'(hyst));
        write_register(blm_pkg::REG_DEBOUNCE,       blm_pkg::CFG_DATA_BITS'(debounce));
        write_register(blm_pkg::REG_SHUTDOWN,       blm_pkg::CFG_DATA_BITS'(timeout));
        write_register(blm_pkg::REG_LOW_WARN_EN,    blm_pkg::CFG_DATA_BITS'(low_en));
        write_register(blm_pkg::REG_CRIT_WARN_EN,   blm_pkg::CFG_DATA_BITS'(crit_en));
        settings_used++;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    task automatic queue_tick(input int smp, input logic usb);
        t_tick t;
        t.sample = blm_pkg::SAMPLE_BITS'(smp);
        t.usb    = usb;
        ticks_to_send.push_back(t);
    endtask

    // Random ticks organized mostly as runs that hover around the current
    // thresholds, so the debounce and hysteresis paths are really taken.
    // The rest is USB episodes, runs of zeros that pull the average back to
    // zero and force a ring fill, full-scale runs and plain noise.
    task automatic queue_random_ticks(input int count);
        int   queued;
        int   kind;
        int   len;
        int   target;
        int   noise;
        int   val;
        logic usb;
        queued = 0;
        while (queued < count) begin
            kind  = $urandom_range(0, 9);
            noise = 0;
            usb   = 1'b0;
            case (kind)
                0: begin
                    len = $urandom_range(1, 8);
                    target = 0;
                end
                1: begin
                    len = $urandom_range(1, 6);
                    target = $urandom_range(0, MAX_SAMPLE);
                    usb = 1'b1;
                end
                2: begin
                    len = $urandom_range(16, 24);
                    target = 0;
                end
                3: begin
                    len = $urandom_range(4, 20);
                    target = MAX_SAMPLE;
                end
                default: begin
                    len   = $urandom_range(4, 30);
                    noise = $urandom_range(0, 8);
                    case ($urandom_range(0, 3))
                        0: target = cfg_shadow.critical_level;
                        1: target = cfg_shadow.low_level;
                        2: target = int'(cfg_shadow.low_level) +
                                    int'(cfg_shadow.hysteresis);
                        default: target = $urandom_range(0, MAX_SAMPLE);
                    endcase
                    target = target + $urandom_range(0, 40) - 20;
                end
            endcase
            for (int j = 0; j < len && queued < count; j++) begin
                if (kind == 0) begin
                    val = $urandom_range(0, MAX_SAMPLE);
                    usb = ($urandom_range(0, 3) == 0);
                end else begin
                    val = target + $urandom_range(0, 2 * noise) - noise;
                end
                if (val < 0) begin
                    val = 0;
                end else if (val > MAX_SAMPLE) begin
                    val = MAX_SAMPLE;
                end
                queue_tick(val, usb);
                queued++;
            end
        end
    endtask

    // Random register setting. Masked registers get junk in their unused
    // upper data bits to show that only the low bits count.
    task automatic apply_random_settings();
        int low_lvl;
        int crit_lvl;
        int hyst;
        int debounce;
        int timeout;
        low_lvl  = $urandom_range(300, 1000);
        crit_lvl = ($urandom_range(0, 4) == 0) ? $urandom_range(0, MAX_SAMPLE)
                                                : $urandom_range(100, low_lvl);
        hyst     = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_SAMPLE)
                                                : $urandom_range(0, 40);
        debounce = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 20)
                                                : $urandom_range(1, 6);
        timeout  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        apply_settings(low_lvl, crit_lvl, hyst,
                       ($urandom_range(0, 3) << 8) | debounce,
                       ($urandom_range(0, 3) << 8) | timeout,
                       ($urandom_range(0, 511) << 1) | $urandom_range(0, 1),
                       ($urandom_range(0, 511) << 1) | $urandom_range(0, 1));
    endtask

    // Waits until every queued tick has been transferred and every report
    // predicted for it has been checked. Each tick yields one report, so the
    // block is idle at that point.
    task automatic wait_until_drained();
        while (ticks_to_send.size() != 0 || i_valid || expected_reports.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Input driver: bursts of ticks with random gaps, changed at the falling
    // edge. A tick stays on the port until its transfer has been seen.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || ticks_accepted == ticks_presented)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (ticks_to_send.size() > 0) begin
                next_tick = ticks_to_send.pop_front();
                i_valid       <= 1'b1;
                i_sample      <= next_tick.sample;
                i_usb_powered <= next_tick.usb;
                ticks_presented++;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 32);
                    kind_gap_select: begin
                        int pick;
                        pick = $urandom_range(0, 9);
                        if (pick < 4) begin
                            gap_left = 0;
                        end else if (pick < 9) begin
                            gap_left = $urandom_range(1, 12);
                        end else begin
                            gap_left = $urandom_range(30, 60);
                        end
                    end
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver stall pattern: runs of ready and stall of random length, now
    // and then a long stall, and long stretches that never stall.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (ready_left <= 0) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    ready_level = 1'b1;
                    ready_left  = $urandom_range(1, 40);
                end
                4, 5, 6, 7: begin
                    ready_level = 1'b0;
                    ready_left  = $urandom_range(1, 12);
                end
                8: begin
                    ready_level = 1'b0;
                    ready_left  = $urandom_range(20, 40);
                end
                default: begin
                    ready_level = 1'b1;
                    ready_left  = $urandom_range(100, 300);
                end
            endcase
        end
        ready_left--;
        i_ready <= ready_level;
    end

    // ------------------------------------------------------------------------
    // Monitor: at each rising edge a tick transfer updates the prediction and
    // a report transfer is checked against the oldest predicted report.
    // ------------------------------------------------------------------------
    task automatic compare_field(input string field, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $display("%0t ns: report %0d %s expected %0d, actual %0d",
                     $time, reports_checked, field, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        blm_pkg::t_result predicted;
        blm_pkg::t_result oldest;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                predict_report(i_sample, i_usb_powered, predicted);
                expected_reports.push_back(predicted);
                ticks_accepted++;
            end
            if (o_valid && i_ready) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t ns: expected no report, actual report with state %0d",
                             $time, o_battery_state);
                    mismatch_count++;
                end else begin
                    oldest = expected_reports.pop_front();
                    compare_field("battery_state", oldest.battery_state, o_battery_state);
                    compare_field("average", oldest.average, o_average);
                    compare_field("low_flag", oldest.low_flag, o_low_flag);
                    compare_field("critical_flag", oldest.critical_flag, o_critical_flag);
                    compare_field("low_warning", oldest.low_warning, o_low_warning);
                    compare_field("critical_warning", oldest.critical_warning,
                                  o_critical_warning);
                    compare_field("power_down", oldest.power_down, o_power_down);
                end
                states_seen[o_battery_state] = 1'b1;
                low_warn_seen   += o_low_warning;
                crit_warn_seen  += o_critical_warning;
                power_down_seen += o_power_down;
                reports_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        clear_level_model();
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed ticks at the reset settings. A zero sample keeps the
        // average at zero so the ring is filled twice in a row; a full-scale
        // sample then fills it again. USB power is entered and left from ok,
        // a run of zeros walks the average down past low straight into critical
        // (with the critical warning and the countdown armed), USB power pulls
        // the block out of critical, and full-scale samples climb back.
        queue_tick(0, 1'b0);
        queue_tick(0, 1'b0);
        queue_tick(MAX_SAMPLE, 1'b0);
        queue_tick(MAX_SAMPLE, 1'b1);
        queue_tick(MAX_SAMPLE, 1'b1);
        queue_tick(MAX_SAMPLE, 1'b0);
        repeat (8) queue_tick(0, 1'b0);
        queue_tick(0, 1'b1);
        queue_tick(0, 1'b0);
        repeat (4) queue_tick(MAX_SAMPLE, 1'b0);
        queue_tick(512, 1'b1);
        queue_tick(512, 1'b0);
        settings_used++;
        wait_until_drained();

        // Debounce of one and a timeout of one: power-down is requested on
        // the tick that enters critical. The unmapped index is written too.
        apply_settings(600, 300, 50, 1, 1, 1, 1);
        write_register(REG_UNMAPPED, 10'h155);
        queue_random_ticks(140);
        wait_until_drained();

        // Upper extremes: the return bound lies beyond full scale, the
        // debounce and timeout are at their maximum, warnings are off.
        // Halfway through, the sender holds off until every report is back.
        apply_settings(MAX_SAMPLE, 0, MAX_SAMPLE, 255, 255, 0, 0);
        queue_random_ticks(150);
        wait_until_drained();
        queue_random_ticks(150);
        wait_until_drained();

        // Lower extremes: zero thresholds, a debounce of zero (upper data
        // bits set) and a disabled countdown. Only bit zero of the data sets
        // a warning enable.
        apply_settings(0, 0, 0, 10'h100, 0, 10'h3FF, 10'h3FE);
        queue_random_ticks(140);
        wait_until_drained();

        repeat (4) begin
            apply_random_settings();
            queue_random_ticks(130);
            wait_until_drained();
        end

        // Leave room for a stray report.
        repeat (40) @(negedge i_clk);
        if (expected_reports.size() != 0) begin
            $display("%0t ns: expected %0d more reports, actual 0",
                     $time, expected_reports.size());
            mismatch_count++;
        end

        $display("Run covered %0d ticks and %0d reports over %0d register settings.",
                 ticks_accepted, reports_checked, settings_used);
        $display("States reached (usb/crit/low/ok) %b; %0d low, %0d critical warnings,",
                 states_seen, low_warn_seen, crit_warn_seen);
        $display("and %0d power-down requests.", power_down_seen);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Safety net well beyond the slowest legitimate run.
    initial begin
        #6000000;
        $display("%0t ns: timeout with %0d ticks queued and %0d reports outstanding",
                 $time, ticks_to_send.size(), expected_reports.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
